[rtl/core/hc_pkg.sv]
// Shared types, codes and codeword functions for the Hamming(12,8) stream codec.
package hc_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Register word index, taken from paddr[2].
  localparam logic REG_MODE = 1'b0;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAN      = 2'd0,
    ST_DATA_FIX   = 2'd1,
    ST_PARITY_ERR = 2'd2,
    ST_UNCORR     = 2'd3
  } hc_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } hc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;
  } hc_out_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
  } hc_dec_t;

  // Result of processing one held input item.
  typedef struct packed {
    logic [1:0]         n;
    hc_out_t [2:0]      res;
    logic [23:0]        buf_next;
    logic [1:0]         cnt_next;
  } hc_step_t;

  // Data bits at positions 3,5,6,7,9,10,11,12; parity at 1,2,4,8.
  function automatic logic [11:0] enc12(input logic [7:0] d);
    logic [11:0] cw;
    cw     = '0;
    cw[2]  = d[0];
    cw[4]  = d[1];
    cw[5]  = d[2];
    cw[6]  = d[3];
    cw[8]  = d[4];
    cw[9]  = d[5];
    cw[10] = d[6];
    cw[11] = d[7];
    cw[0]  = d[0] ^ d[1] ^ d[3] ^ d[4] ^ d[6];
    cw[1]  = d[0] ^ d[2] ^ d[3] ^ d[5] ^ d[6];
    cw[3]  = d[1] ^ d[2] ^ d[3] ^ d[7];
    cw[7]  = d[4] ^ d[5] ^ d[6] ^ d[7];
    return cw;
  endfunction

  function automatic hc_dec_t dec12(input logic [11:0] cw);
    hc_dec_t    r;
    logic [7:0] d;
    logic [3:0] syn;
    d      = {cw[11], cw[10], cw[9], cw[8], cw[6], cw[5], cw[4], cw[2]};
    syn[0] = cw[0] ^ d[0] ^ d[1] ^ d[3] ^ d[4] ^ d[6];
    syn[1] = cw[1] ^ d[0] ^ d[2] ^ d[3] ^ d[5] ^ d[6];
    syn[2] = cw[3] ^ d[1] ^ d[2] ^ d[3] ^ d[7];
    syn[3] = cw[7] ^ d[4] ^ d[5] ^ d[6] ^ d[7];
    r.data   = d;
    r.status = ST_CLEAN;
    if (syn == 4'd0) begin
      r.status = ST_CLEAN;
    end else if (syn > 4'd12) begin
      r.status = ST_UNCORR;
    end else if ((syn & (syn - 4'd1)) == 4'd0) begin
      r.status = ST_PARITY_ERR;
    end else begin
      r.status = ST_DATA_FIX;
      case (syn)
        4'd3:    r.data[0] = ~d[0];
        4'd5:    r.data[1] = ~d[1];
        4'd6:    r.data[2] = ~d[2];
        4'd7:    r.data[3] = ~d[3];
        4'd9:    r.data[4] = ~d[4];
        4'd10:   r.data[5] = ~d[5];
        4'd11:   r.data[6] = ~d[6];
        4'd12:   r.data[7] = ~d[7];
        default: r.data = d;
      endcase
    end
    return r;
  endfunction

endpackage

[rtl/core/hamming_12_8_stream_codec_top.sv]
// Top level of the Hamming(12,8) byte-stream codec: channels, registers, result queue.
//
// Usage:
//   src_* carries source bytes (data_byte, last); dst_* carries result bytes
//   (out_byte, out_last, status). Both are valid/ready channels.
//   The APB port holds one register, mode at address 0 (0 encode, 1 decode);
//   writing it clears the partial group. Write it only while the block is idle.
//   Encode: every second byte yields 3 packed bytes; a last byte on an odd count
//   yields 2. Decode: every third byte yields 2 corrected bytes; a last byte
//   with a short group yields 1. Other bytes yield nothing.
// With the queue free, an input passes the input register, then the result
//   register, before its first result is valid on dst_*.
// Throughput: one input per cycle while it produces no result; an input that
//   produces results waits until the 3-entry result queue is empty or draining
//   its last entry, so the single output port sets the pace at one byte per
//   cycle while the receiver is ready.
// Reset: rst clears mode to encode, the group, the input register and queue.
// A stalled receiver holds the queue; an input that produces results then waits
//   in the input register and src_ready drops until the queue drains.
module hamming_12_8_stream_codec_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       src_valid,
  output logic                       src_ready,
  input  hc_pkg::hc_in_t             src_item,
  output logic                       dst_valid,
  input  logic                       dst_ready,
  output hc_pkg::hc_out_t            dst_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hc_pkg::ADDR_W-1:0]  paddr,
  input  logic [hc_pkg::DATA_W-1:0]  pwdata,
  output logic [hc_pkg::DATA_W-1:0]  prdata,
  output logic                       pready
);

  logic             mode;
  logic             held;
  hc_pkg::hc_in_t   hold_item;
  logic [23:0]      grp_buf;
  logic [1:0]       grp_cnt;
  hc_pkg::hc_out_t  q [3];
  logic [1:0]       q_rd;
  logic [1:0]       q_rem;
  hc_pkg::hc_step_t step;
  logic             q_free;
  logic             fire;
  logic             cfg_wr;

  hc_codec u_codec (
    .mode    (mode),
    .grp_buf (grp_buf),
    .grp_cnt (grp_cnt),
    .item    (hold_item),
    .step    (step)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == hc_pkg::REG_MODE) ? {{(hc_pkg::DATA_W-1){1'b0}}, mode} : '0;

  assign q_free    = (q_rem == 2'd0) || ((q_rem == 2'd1) && dst_ready);
  assign fire      = held && ((step.n == 2'd0) || q_free);
  assign src_ready = !held || fire;
  assign dst_valid = (q_rem != 2'd0);

  always_comb begin
    case (q_rd)
      2'd1:    dst_item = q[1];
      2'd2:    dst_item = q[2];
      default: dst_item = q[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= hc_pkg::MODE_ENCODE;
      held    <= 1'b0;
      grp_buf <= '0;
      grp_cnt <= '0;
      q_rd    <= '0;
      q_rem   <= '0;
    end else begin
      if (cfg_wr && (paddr[2] == hc_pkg::REG_MODE)) begin
        mode    <= pwdata[0];
        grp_buf <= '0;
        grp_cnt <= '0;
      end else if (fire) begin
        grp_buf <= step.buf_next;
        grp_cnt <= step.cnt_next;
      end
      if (src_ready) begin
        held <= src_valid;
      end
      if (fire && (step.n != 2'd0)) begin
        q_rem <= step.n;
        q_rd  <= 2'd0;
      end else if (dst_valid && dst_ready) begin
        q_rem <= q_rem - 2'd1;
        q_rd  <= q_rd + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      hold_item <= src_item;
    end
    if (fire && (step.n != 2'd0)) begin
      q[0] <= step.res[0];
      q[1] <= step.res[1];
      q[2] <= step.res[2];
    end
  end

  // encode never holds more than one codeword
  a_enc_cnt : assert property (@(posedge clk) disable iff (rst)
    (mode == hc_pkg::MODE_ENCODE) |-> (grp_cnt <= 2'd1))
    else $error("encode group count above one");

  a_dec_cnt : assert property (@(posedge clk) disable iff (rst)
    grp_cnt != 2'd3)
    else $error("group count reached three");

  // the final queued entry closes the transfer group, earlier ones do not
  a_last_tail : assert property (@(posedge clk) disable iff (rst)
    (q_rem == 2'd1) |-> dst_item.out_last)
    else $error("final queued result without out_last");

  a_last_early : assert property (@(posedge clk) disable iff (rst)
    (q_rem > 2'd1) |-> !dst_item.out_last)
    else $error("out_last before the final queued result");

  a_enc_status : assert property (@(posedge clk) disable iff (rst)
    (dst_valid && (mode == hc_pkg::MODE_ENCODE)) |-> (dst_item.status == hc_pkg::ST_CLEAN))
    else $error("nonzero status in encode mode");

endmodule

[rtl/core/hc_codec.sv]
// Single-pass encode/decode of one byte against the current group state.
module hc_codec (
  input  logic            mode,
  input  logic [23:0]     grp_buf,
  input  logic [1:0]      grp_cnt,
  input  hc_pkg::hc_in_t  item,
  output hc_pkg::hc_step_t step
);

  logic [11:0]     enc_word;
  logic [23:0]     full;
  logic [1:0]      slot;
  logic [23:0]     merged;
  hc_pkg::hc_dec_t dec_lo;
  hc_pkg::hc_dec_t dec_hi;

  assign enc_word = hc_pkg::enc12(item.data_byte);
  assign full     = {enc_word, grp_buf[11:0]};
  assign slot     = (grp_cnt > 2'd2) ? 2'd2 : grp_cnt;

  always_comb begin
    case (slot)
      2'd0:    merged = grp_buf | {16'b0, item.data_byte};
      2'd1:    merged = grp_buf | {8'b0, item.data_byte, 8'b0};
      default: merged = grp_buf | {item.data_byte, 16'b0};
    endcase
  end

  assign dec_lo = hc_pkg::dec12(merged[11:0]);
  assign dec_hi = hc_pkg::dec12(merged[23:12]);

  always_comb begin
    step = '0;
    if (mode == hc_pkg::MODE_ENCODE) begin
      if (grp_cnt == 2'd0) begin
        if (item.last) begin
          // odd tail: one codeword over two bytes
          step.n      = 2'd2;
          step.res[0] = {enc_word[7:0], 1'b0, hc_pkg::ST_CLEAN};
          step.res[1] = {4'b0, enc_word[11:8], 1'b1, hc_pkg::ST_CLEAN};
        end else begin
          step.buf_next = {12'b0, enc_word};
          step.cnt_next = 2'd1;
        end
      end else begin
        step.n      = 2'd3;
        step.res[0] = {full[7:0], 1'b0, hc_pkg::ST_CLEAN};
        step.res[1] = {full[15:8], 1'b0, hc_pkg::ST_CLEAN};
        step.res[2] = {full[23:16], 1'b1, hc_pkg::ST_CLEAN};
      end
    end else begin
      if (slot == 2'd2) begin
        step.n      = 2'd2;
        step.res[0] = {dec_lo.data, 1'b0, dec_lo.status};
        step.res[1] = {dec_hi.data, 1'b1, dec_hi.status};
      end else if (item.last) begin
        step.n      = 2'd1;
        step.res[0] = {dec_lo.data, 1'b1, dec_lo.status};
      end else begin
        step.buf_next = merged;
        step.cnt_next = slot + 2'd1;
      end
    end
  end

endmodule
